@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// All checks are clocked on the rising edge and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every edge.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bsoc_pkg.sv @@
`timescale 1ns / 1ps

package bsoc_pkg;

   // field widths
   localparam int MV_W       = 13;
   localparam int GAUGE_W    = 16;
   localparam int REST_W     = 15;
   localparam int RESID_W    = 17;
   localparam int THR_W      = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // resting OCV curve
   localparam int KNOT_COUNT = 12;
   localparam int SEG_COUNT  = KNOT_COUNT - 1;
   localparam int SEG_W      = $clog2(SEG_COUNT);
   localparam int DELTA_W    = 9;   // widest segment spans 300 mV

   localparam logic [MV_W-1:0] KNOT_MV [KNOT_COUNT] = '{
      13'd3000, 13'd3300, 13'd3500, 13'd3600, 13'd3700, 13'd3800,
      13'd3900, 13'd3950, 13'd4000, 13'd4050, 13'd4100, 13'd4200
   };

   localparam logic [REST_W-1:0] KNOT_SOC [KNOT_COUNT] = '{
      15'd0,     15'd1280,  15'd2560,  15'd5120,  15'd7680,  15'd10240,
      15'd12800, 15'd15360, 15'd17920, 15'd20480, 15'd23040, 15'd25600
   };

   // slope of each segment written as (1 << shift) / divisor, divisor 5 or 15
   localparam logic [3:0] SEG_SHIFT [SEG_COUNT] = '{
      4'd6, 4'd5, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7
   };

   localparam logic SEG_DIV15 [SEG_COUNT] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };

   // reciprocals, exact for numerators below 2^15 (div 5) and 23831 (div 15)
   localparam int                 RECIP_SHIFT = 18;
   localparam int                 RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP_DIV5  = 16'd52429;
   localparam logic [RECIP_W-1:0] RECIP_DIV15 = 16'd17477;
   localparam int                 PROD_W      = REST_W + RECIP_W;

   localparam logic [REST_W-1:0] SOC_FULL = 15'd25600;

   // register reset values
   localparam logic [THR_W-1:0] UNTRUSTED_RST = 15'd5120;
   localparam logic [THR_W-1:0] SUSPECT_RST   = 15'd3072;
   localparam logic [THR_W-1:0] BIAS_RST      = 15'd2048;
   localparam logic [MV_W-1:0]  USABLE_LO_RST = 13'd2500;
   localparam logic [MV_W-1:0]  USABLE_HI_RST = 13'd5000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNTRUSTED_THR = 3'd0,
      CSR_SUSPECT_THR   = 3'd1,
      CSR_BIAS_ALLOW    = 3'd2,
      CSR_USABLE_LO     = 3'd3,
      CSR_USABLE_HI     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      TRUST_OK        = 2'd0,
      TRUST_SUSPECT   = 2'd1,
      TRUST_UNTRUSTED = 2'd2
   } trust_type;

   // segment lookup result for one voltage
   typedef struct packed {
      logic              clamp_lo;
      logic              clamp_hi;
      logic [REST_W-1:0] s0;
      logic [REST_W-1:0] numer;   // (mv - v0) << shift
      logic              div15;
   } seg_type;

endpackage

@@ hdl/bsoc_req_if.sv @@
`timescale 1ns / 1ps

interface bsoc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsoc_pkg::GAUGE_W-1:0]  gauge_soc;
   logic [bsoc_pkg::MV_W-1:0]     cell_mv;
   logic                          charging_active;
   logic                          radio_active;

   modport source (output valid, gauge_soc, cell_mv, charging_active, radio_active,
                   input ready);
   modport sink   (input valid, gauge_soc, cell_mv, charging_active, radio_active,
                   output ready);
endinterface

@@ hdl/bsoc_rsp_if.sv @@
`timescale 1ns / 1ps

interface bsoc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bsoc_pkg::REST_W-1:0]         resting_soc;
   logic signed [bsoc_pkg::RESID_W-1:0] residual;
   logic                                voltage_usable;
   logic [1:0]                          trust_level;

   modport source (output valid, resting_soc, residual, voltage_usable, trust_level,
                   input ready);
   modport sink   (input valid, resting_soc, residual, voltage_usable, trust_level,
                   output ready);
endinterface

@@ hdl/bsoc_csr_if.sv @@
`timescale 1ns / 1ps

interface bsoc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bsoc_pkg::CSR_IDX_W-1:0]  index;
   logic [bsoc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/bsoc_seg_lookup.sv @@
`timescale 1ns / 1ps

// Picks the OCV segment holding a voltage and forms the scaled offset into it.
module bsoc_seg_lookup (
   input  logic [bsoc_pkg::MV_W-1:0] cell_mv,
   output bsoc_pkg::seg_type         seg
);

   logic [bsoc_pkg::SEG_W-1:0]   seg_idx;
   logic [bsoc_pkg::DELTA_W-1:0] delta_short;

   // last knot strictly below the voltage; a voltage on a knot uses the lower segment
   always_comb begin
      seg_idx = '0;
      for (int i = 0; i < bsoc_pkg::SEG_COUNT; i++) begin
         if (cell_mv > bsoc_pkg::KNOT_MV[i]) begin
            seg_idx = bsoc_pkg::SEG_W'(i);
         end
      end
   end

   // offset into the segment; only meaningful when neither clamp applies
   assign delta_short = bsoc_pkg::DELTA_W'(cell_mv - bsoc_pkg::KNOT_MV[seg_idx]);

   always_comb begin
      seg.clamp_lo = (cell_mv <= bsoc_pkg::KNOT_MV[0]);
      seg.clamp_hi = (cell_mv >= bsoc_pkg::KNOT_MV[bsoc_pkg::KNOT_COUNT-1]);
      seg.s0       = bsoc_pkg::KNOT_SOC[seg_idx];
      seg.numer    = bsoc_pkg::REST_W'({{(bsoc_pkg::REST_W-bsoc_pkg::DELTA_W){1'b0}},
                                        delta_short} << bsoc_pkg::SEG_SHIFT[seg_idx]);
      seg.div15    = bsoc_pkg::SEG_DIV15[seg_idx];
   end

endmodule

@@ hdl/battery_soc_trust_classifier.sv @@
// An item accepted on req is registered in stages A, B, C and D in turn; rsp shows stage D.
// Throughput: one item per cycle while rsp is ready; four register stages advance independently,
// so a bubble is squeezed out and a stalled output still lets req take an item while a stage is empty.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults; no clearing pass, csr writes are taken every cycle outside reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_soc_trust_classifier (
   input  logic        clock,
   input  logic        reset,
   bsoc_req_if.sink    req_ch,
   bsoc_rsp_if.source  rsp_ch,
   bsoc_csr_if.sink    csr_ch
);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are only expected while idle, so the
   // stages read them directly with no shadow copy.
   // ---------------------------------------------------------------------
   logic [bsoc_pkg::THR_W-1:0] untrusted_thr_ff;
   logic [bsoc_pkg::THR_W-1:0] suspect_thr_ff;
   logic [bsoc_pkg::THR_W-1:0] bias_allow_ff;
   logic [bsoc_pkg::MV_W-1:0]  usable_lo_ff;
   logic [bsoc_pkg::MV_W-1:0]  usable_hi_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         untrusted_thr_ff <= bsoc_pkg::UNTRUSTED_RST;
         suspect_thr_ff   <= bsoc_pkg::SUSPECT_RST;
         bias_allow_ff    <= bsoc_pkg::BIAS_RST;
         usable_lo_ff     <= bsoc_pkg::USABLE_LO_RST;
         usable_hi_ff     <= bsoc_pkg::USABLE_HI_RST;
      end else if (csr_ch.valid) begin
         // unknown indexes fall through and are dropped
         unique case (bsoc_pkg::csr_index_type'(csr_ch.index))
            bsoc_pkg::CSR_UNTRUSTED_THR: untrusted_thr_ff <= csr_ch.data;
            bsoc_pkg::CSR_SUSPECT_THR:   suspect_thr_ff   <= csr_ch.data;
            bsoc_pkg::CSR_BIAS_ALLOW:    bias_allow_ff    <= csr_ch.data;
            bsoc_pkg::CSR_USABLE_LO:     usable_lo_ff     <= csr_ch.data[bsoc_pkg::MV_W-1:0];
            bsoc_pkg::CSR_USABLE_HI:     usable_hi_ff     <= csr_ch.data[bsoc_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage enables. A stage loads when it is empty or its contents move on,
   // so each valid bit only waits on the stages in front of it.
   // ---------------------------------------------------------------------
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic en_a, en_b, en_c, en_d;

   assign en_d = !d_v_ff || rsp_ch.ready;
   assign en_c = !c_v_ff || en_d;
   assign en_b = !b_v_ff || en_c;
   assign en_a = !a_v_ff || en_b;

   assign req_ch.ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (en_a) a_v_ff <= req_ch.valid;
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
         if (en_d) d_v_ff <= c_v_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: input register.
   // ---------------------------------------------------------------------
   logic [bsoc_pkg::GAUGE_W-1:0] a_gauge_ff;
   logic [bsoc_pkg::MV_W-1:0]    a_mv_ff;
   logic                         a_chg_ff, a_radio_ff;

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_gauge_ff <= req_ch.gauge_soc;
         a_mv_ff    <= req_ch.cell_mv;
         a_chg_ff   <= req_ch.charging_active;
         a_radio_ff <= req_ch.radio_active;
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: segment search over the knot table and the usable window.
   // ---------------------------------------------------------------------
   bsoc_pkg::seg_type a_seg;
   logic              a_usable;

   bsoc_seg_lookup u_seg_lookup (
      .cell_mv (a_mv_ff),
      .seg     (a_seg)
   );

   assign a_usable = (a_mv_ff > usable_lo_ff) && (a_mv_ff < usable_hi_ff);

   bsoc_pkg::seg_type            b_seg_ff;
   logic [bsoc_pkg::GAUGE_W-1:0] b_gauge_ff;
   logic                         b_chg_ff, b_radio_ff, b_usable_ff;

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_seg_ff    <= a_seg;
         b_gauge_ff  <= a_gauge_ff;
         b_chg_ff    <= a_chg_ff;
         b_radio_ff  <= a_radio_ff;
         b_usable_ff <= a_usable;
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: truncating divide by the segment's divisor (5 or 15) through a
   // reciprocal multiply, then add the knot's base and apply the end clamps.
   // ---------------------------------------------------------------------
   logic [bsoc_pkg::RECIP_W-1:0] b_recip;
   logic [bsoc_pkg::PROD_W-1:0]  b_prod;
   logic [bsoc_pkg::REST_W-1:0]  b_quot;
   logic [bsoc_pkg::REST_W-1:0]  b_rest;

   assign b_recip = b_seg_ff.div15 ? bsoc_pkg::RECIP_DIV15 : bsoc_pkg::RECIP_DIV5;
   assign b_prod  = {{bsoc_pkg::RECIP_W{1'b0}}, b_seg_ff.numer} *
                    {{bsoc_pkg::REST_W{1'b0}}, b_recip};
   assign b_quot  = bsoc_pkg::REST_W'(b_prod >> bsoc_pkg::RECIP_SHIFT);

   always_comb begin
      if (b_seg_ff.clamp_lo) begin
         b_rest = bsoc_pkg::KNOT_SOC[0];
      end else if (b_seg_ff.clamp_hi) begin
         b_rest = bsoc_pkg::KNOT_SOC[bsoc_pkg::KNOT_COUNT-1];
      end else begin
         b_rest = b_seg_ff.s0 + b_quot;
      end
   end

   logic [bsoc_pkg::REST_W-1:0]  c_rest_ff;
   logic [bsoc_pkg::GAUGE_W-1:0] c_gauge_ff;
   logic                         c_chg_ff, c_radio_ff, c_usable_ff;

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_rest_ff   <= b_rest;
         c_gauge_ff  <= b_gauge_ff;
         c_chg_ff    <= b_chg_ff;
         c_radio_ff  <= b_radio_ff;
         c_usable_ff <= b_usable_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: residual and classification. Charging widens the negative
   // band, radio load the positive band. Untrusted is tested first.
   // ---------------------------------------------------------------------
   localparam int BAND_W = bsoc_pkg::THR_W + 1;
   localparam int CMP_W  = bsoc_pkg::RESID_W + 1;

   logic signed [bsoc_pkg::RESID_W-1:0] c_resid;
   logic signed [CMP_W-1:0]             c_resid_x;
   logic [BAND_W-1:0]                   c_neg_extra, c_pos_extra;
   logic [BAND_W-1:0]                   c_neg_u, c_pos_u, c_neg_s, c_pos_s;
   logic                                c_hit_u, c_hit_s;
   bsoc_pkg::trust_type                 c_trust;

   assign c_resid   = $signed({1'b0, c_gauge_ff}) - $signed({2'b0, c_rest_ff});
   assign c_resid_x = {c_resid[bsoc_pkg::RESID_W-1], c_resid};

   assign c_neg_extra = c_chg_ff   ? {1'b0, bias_allow_ff} : '0;
   assign c_pos_extra = c_radio_ff ? {1'b0, bias_allow_ff} : '0;
   assign c_neg_u     = {1'b0, untrusted_thr_ff} + c_neg_extra;
   assign c_pos_u     = {1'b0, untrusted_thr_ff} + c_pos_extra;
   assign c_neg_s     = {1'b0, suspect_thr_ff}   + c_neg_extra;
   assign c_pos_s     = {1'b0, suspect_thr_ff}   + c_pos_extra;

   assign c_hit_u = (c_resid_x <= -$signed({2'b0, c_neg_u})) ||
                    (c_resid_x >=  $signed({2'b0, c_pos_u}));
   assign c_hit_s = (c_resid_x <= -$signed({2'b0, c_neg_s})) ||
                    (c_resid_x >=  $signed({2'b0, c_pos_s}));

   always_comb begin
      if (!c_usable_ff || c_hit_u) begin
         c_trust = bsoc_pkg::TRUST_UNTRUSTED;
      end else if (c_hit_s) begin
         c_trust = bsoc_pkg::TRUST_SUSPECT;
      end else begin
         c_trust = bsoc_pkg::TRUST_OK;
      end
   end

   // output register, held while the sink stalls
   logic [bsoc_pkg::REST_W-1:0]         d_rest_ff;
   logic signed [bsoc_pkg::RESID_W-1:0] d_resid_ff;
   logic                                d_usable_ff;
   bsoc_pkg::trust_type                 d_trust_ff;

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_rest_ff   <= c_rest_ff;
         d_resid_ff  <= c_resid;
         d_usable_ff <= c_usable_ff;
         d_trust_ff  <= c_trust;
      end
   end

   assign rsp_ch.valid          = d_v_ff;
   assign rsp_ch.resting_soc    = d_rest_ff;
   assign rsp_ch.residual       = d_resid_ff;
   assign rsp_ch.voltage_usable = d_usable_ff;
   assign rsp_ch.trust_level    = d_trust_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ASSERT_IMPLIES(a_unusable_untrusted, clock, reset, d_v_ff && !d_usable_ff,
      d_trust_ff == bsoc_pkg::TRUST_UNTRUSTED, "unusable voltage not classed untrusted")
   `ASSERT_IMPLIES(a_rest_in_range, clock, reset, d_v_ff,
      d_rest_ff <= bsoc_pkg::SOC_FULL, "resting estimate above full scale")
   `ASSERT_NEXT(a_item_moves_out, clock, reset, c_v_ff && en_d,
      d_v_ff, "item lost between classify and output stage")
   `ASSERT_IMPLIES(a_full_blocks_req, clock, reset, a_v_ff && !en_b,
      !req_ch.ready, "input taken while stage A is stuck")

endmodule
